// ===== hw/rtl/antireplay_slot_window_macros.svh =====
// Assertion helpers for the anti-replay window checks.
`ifndef ANTIREPLAY_SLOT_WINDOW_MACROS_SVH
`define ANTIREPLAY_SLOT_WINDOW_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ASW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define ASW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/asw_pkg.sv =====
`timescale 1ns / 1ps

package asw_pkg;

    localparam int SEQ_W     = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 4;
    localparam int WBITS_W   = 4;
    localparam int LINE_LOG2 = 3;

    typedef logic [1:0] verdict_t;

    localparam verdict_t VERDICT_PASS   = 2'd0;
    localparam verdict_t VERDICT_REPLAY = 2'd1;
    localparam verdict_t VERDICT_STALE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWIZZLE     = 1'b1;

    localparam logic [WBITS_W-1:0] WINDOW_BITS_RST = 4'd10;

    // controller -> datapath
    typedef struct packed {
        logic clear;   // write zero at clear counter, advance it
        logic accept;  // capture request, compute slot index
        logic read;    // read slot into data register
        logic finish;  // load result, write back on update
    } asw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } asw_stat_t;

endpackage

// ===== hw/rtl/antireplay_slot_window.sv =====
`timescale 1ns / 1ps

// Anti-replay check over a table of the highest sequence numbers seen.
// Each request carries a 64-bit seq_num and an op (0 test only, 1 test and
// keep the larger value). The slot is seq_num masked to 2^window_bits entries
// (and to the table size); with swizzle set the low line bits are XORed into
// the bits above them first. verdict: 0 pass (above slot), 1 replay (equal),
// 2 stale (below); an update uses the slot's value from before the write.
// Timing: after reset the block zeroes the table, one entry per cycle, with
// in_stall high; configuration writes are taken during that pass. After that
// one request is in flight at a time: accept, table read, then compare and
// write back, which waits while a result is held on out_stall. The output
// register lets the next request enter while a result waits on out_stall.
// Configuration: index 0 window_bits (4 bits, reset 10), index 1 swizzle
// (bit 0, reset 0); write only while no request is outstanding.

module antireplay_slot_window
    import asw_pkg::*;
#(
    parameter int WINDOW_SIZE = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [SEQ_W-1:0]     seq_num,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           verdict
);

    asw_cmd_t  cmd;
    asw_stat_t stat;

    // sequencing: clear pass, accept, read, compare/write back
    asw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // slot table, index logic, config and result register
    asw_dp #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .seq_num   (seq_num),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== hw/rtl/asw_ctrl.sv =====
`timescale 1ns / 1ps

module asw_ctrl
    import asw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  asw_stat_t stat,
    output asw_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CMP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/asw_dp.sv =====
`timescale 1ns / 1ps

module asw_dp
    import asw_pkg::*;
#(
    parameter int WINDOW_SIZE = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 op,
    input  logic [SEQ_W-1:0]     seq_num,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           verdict,
    input  asw_cmd_t             cmd,
    output asw_stat_t            stat
);

    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam logic [IDX_W-1:0] IDX_LIM  = IDX_W'(WINDOW_SIZE - 1);
    localparam logic [IDX_W:0]   IDX_SIZE = (IDX_W + 1)'(WINDOW_SIZE);

    logic [SEQ_W-1:0] mem [WINDOW_SIZE];

    logic [WBITS_W-1:0] window_bits_reg;
    logic               swizzle_reg;
    logic [IDX_W-1:0]   clear_cnt_reg;
    logic               op_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [SEQ_W-1:0]   slot_reg;
    logic               out_valid_reg;
    verdict_t           verdict_reg;
    verdict_t           verdict_next;

    logic [SEQ_W-1:0]   sn_x;
    logic [IDX_W-1:0]   win_mask;
    logic [IDX_W-1:0]   idx_raw;
    logic               pass;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [SEQ_W-1:0]   mem_wdata;

    // slot index: optional line swizzle, window mask, table bound
    always_comb
    begin
        sn_x = seq_num;
        if (swizzle_reg)
        begin
            sn_x = seq_num ^ ({{(SEQ_W - LINE_LOG2){1'b0}}, seq_num[LINE_LOG2-1:0]}
                              << LINE_LOG2);
        end
        for (int i = 0; i < IDX_W; i++)
        begin
            win_mask[i] = (i < int'(window_bits_reg)) && IDX_LIM[i];
        end
        idx_raw = sn_x[IDX_W-1:0] & win_mask;
        if ({1'b0, idx_raw} >= IDX_SIZE)
        begin
            idx_next = '0;
        end
        else
        begin
            idx_next = idx_raw;
        end
    end

    assign pass = (seq_reg > slot_reg);

    always_comb
    begin
        if (pass)
        begin
            verdict_next = VERDICT_PASS;
        end
        else if (seq_reg == slot_reg)
        begin
            verdict_next = VERDICT_REPLAY;
        end
        else
        begin
            verdict_next = VERDICT_STALE;
        end
    end

    assign mem_we    = cmd.clear || (cmd.finish && op_reg && pass);
    assign mem_waddr = cmd.clear ? clear_cnt_reg : idx_reg;
    assign mem_wdata = cmd.clear ? '0 : seq_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read)
        begin
            slot_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= op;
            seq_reg <= seq_num;
            idx_reg <= idx_next;
        end
        if (cmd.finish)
        begin
            verdict_reg <= verdict_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_bits_reg <= WINDOW_BITS_RST;
            swizzle_reg     <= 1'b0;
            clear_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WINDOW_BITS: window_bits_reg <= cfg_data[WBITS_W-1:0];
                    CFG_SWIZZLE:     swizzle_reg     <= cfg_data[0];
                    default:         ;
                endcase
            end
            if (cmd.clear)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clear_last = (clear_cnt_reg == IDX_LIM);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule

// ===== hw/rtl/asw_checker.sv =====
`timescale 1ns / 1ps
`include "antireplay_slot_window_macros.svh"

module asw_checker
    import asw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] verdict
);

    // one request in flight: the cycle after an accept is stalled
    `ASW_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "request taken while busy")

    // a new result only follows a busy cycle
    `ASW_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall), "result with no work")

    // only the three defined verdicts
    `ASW_ASSERT_NOW(a_verdict_code, out_valid, verdict != 2'd3, "undefined verdict code")

    // stalled result holds
    `ASW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(verdict), "stalled result changed")

endmodule

bind antireplay_slot_window asw_checker u_asw_checker (.*);
